### hdl/tsoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-sync offset averager: shared definitions
// Window depth, derived widths and the command/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package tsoa_pkg;

  // Number of exchanges kept in the averaging window (1 .. 7).
  localparam int WINDOW_DEPTH = 5;

  localparam int TS_W        = 64;
  localparam int SAMPLES_W   = 3;
  localparam int IN_TDATA_W  = 4 * TS_W;
  localparam int OUT_FIELD_W = 2 * TS_W + SAMPLES_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Sample count 0 .. WINDOW_DEPTH and ring index 0 .. WINDOW_DEPTH-1.
  localparam int TALLY_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  // Exact window sum: 64 bits plus headroom for WINDOW_DEPTH terms.
  localparam int ACC_W     = TS_W + $clog2(WINDOW_DEPTH + 1);
  localparam int DIV_CNT_W = $clog2(ACC_W);

  localparam logic [TALLY_W-1:0]   TALLY_MAX = TALLY_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0]     SLOT_LAST = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(ACC_W - 1);

  typedef struct packed {
    logic             capture;
    logic             diff;
    logic             calc;
    logic             write;
    logic             acc_clear;
    logic             acc_add;
    logic [IDX_W-1:0] rd_idx;
    logic             div_load;
    logic             div_step;
    logic             res_load;
  } tsoa_cmd_t;

  typedef struct packed {
    logic [TALLY_W-1:0] tally;
  } tsoa_stat_t;

endpackage

### hdl/tsoa_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-sync offset averager: bit-serial divider lane
// Restoring division of a signed window sum by the sample count, one
// quotient bit per step, truncated toward zero.
// ----------------------------------------------------------------------------
module tsoa_div_lane (
  input  logic                             clk,
  input  logic                             load,
  input  logic                             step,
  input  logic signed [tsoa_pkg::ACC_W-1:0] dividend,
  input  logic [tsoa_pkg::TALLY_W-1:0]     divisor,
  output logic signed [tsoa_pkg::TS_W-1:0] quotient
);

  logic [tsoa_pkg::TALLY_W-1:0] rem_r;
  logic [tsoa_pkg::ACC_W-1:0]   quo_r;
  logic                         neg_r;

  logic [tsoa_pkg::TALLY_W:0]   rem_sh;
  logic [tsoa_pkg::TALLY_W:0]   trial;
  logic [tsoa_pkg::ACC_W-1:0]   mag;
  logic [tsoa_pkg::TS_W-1:0]    quo_low;

  assign mag    = dividend[tsoa_pkg::ACC_W-1] ? (tsoa_pkg::ACC_W'(0) - dividend) : dividend;
  assign rem_sh = {rem_r, quo_r[tsoa_pkg::ACC_W-1]};
  assign trial  = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= '0;
      quo_r <= mag;
      neg_r <= dividend[tsoa_pkg::ACC_W-1];
    end else if (step) begin
      if (!trial[tsoa_pkg::TALLY_W]) begin
        rem_r <= trial[tsoa_pkg::TALLY_W-1:0];
        quo_r <= {quo_r[tsoa_pkg::ACC_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[tsoa_pkg::TALLY_W-1:0];
        quo_r <= {quo_r[tsoa_pkg::ACC_W-2:0], 1'b0};
      end
    end
  end

  // Restore the sign on the low word of the magnitude quotient.
  assign quo_low  = quo_r[tsoa_pkg::TS_W-1:0];
  assign quotient = neg_r ? (tsoa_pkg::TS_W'(0) - quo_low) : quo_low;

endmodule

### hdl/tsoa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-sync offset averager: datapath
// Timestamp differences, offset/round-trip rings, window sums, two divider
// lanes and the result register.
// ----------------------------------------------------------------------------
module tsoa_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [tsoa_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  tsoa_pkg::tsoa_cmd_t                 cmd,
  output tsoa_pkg::tsoa_stat_t                stat,
  output logic [tsoa_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int W = tsoa_pkg::TS_W;
  localparam int A = tsoa_pkg::ACC_W;

  logic [W-1:0] t1_r, t2_r, t3_r, t4_r;
  logic [W-1:0] d21_r, d34_r, d41_r, d23_r;
  logic [W-1:0] off_raw_r, rtt_r;
  logic [W-1:0] off_ring_r [tsoa_pkg::WINDOW_DEPTH];
  logic [W-1:0] rtt_ring_r [tsoa_pkg::WINDOW_DEPTH];
  logic signed [A-1:0] off_acc_r, rtt_acc_r;

  logic [tsoa_pkg::IDX_W-1:0]   slot_r, slot_nxt;
  logic [tsoa_pkg::TALLY_W-1:0] tally_r, tally_nxt;

  logic [W-1:0] off_rnd;
  logic [W-1:0] off_half;
  logic [W-1:0] off_rd, rtt_rd;
  logic signed [W-1:0] off_mean, rtt_mean;
  logic signed [W-1:0] off_mean_r, rtt_mean_r;
  logic [tsoa_pkg::SAMPLES_W-1:0] samples_r;

  // Halve toward zero: bias negatives by one before the arithmetic shift.
  assign off_rnd  = off_raw_r + W'(off_raw_r[W-1]);
  assign off_half = {off_rnd[W-1], off_rnd[W-1:1]};

  assign off_rd = off_ring_r[cmd.rd_idx];
  assign rtt_rd = rtt_ring_r[cmd.rd_idx];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t1_r <= in_tdata[W-1:0];
      t2_r <= in_tdata[2*W-1:W];
      t3_r <= in_tdata[3*W-1:2*W];
      t4_r <= in_tdata[4*W-1:3*W];
    end
    if (cmd.diff) begin
      d21_r <= t2_r - t1_r;
      d34_r <= t3_r - t4_r;
      d41_r <= t4_r - t1_r;
      d23_r <= t2_r - t3_r;
    end
    if (cmd.calc) begin
      off_raw_r <= d21_r - d34_r;
      rtt_r     <= d41_r - d23_r;
    end
    if (cmd.write) begin
      off_ring_r[slot_r] <= off_half;
      rtt_ring_r[slot_r] <= rtt_r;
    end
    if (cmd.acc_clear) begin
      off_acc_r <= '0;
      rtt_acc_r <= '0;
    end else if (cmd.acc_add) begin
      off_acc_r <= off_acc_r + {{(A - W){off_rd[W-1]}}, off_rd};
      rtt_acc_r <= rtt_acc_r + {{(A - W){rtt_rd[W-1]}}, rtt_rd};
    end
    if (cmd.res_load) begin
      off_mean_r <= off_mean;
      rtt_mean_r <= rtt_mean;
      samples_r  <= tsoa_pkg::SAMPLES_W'(tally_r);
    end
  end

  always_comb begin
    slot_nxt  = slot_r;
    tally_nxt = tally_r;
    if (cmd.write) begin
      slot_nxt = (slot_r == tsoa_pkg::SLOT_LAST) ? '0 : slot_r + 1'b1;
      if (tally_r != tsoa_pkg::TALLY_MAX) begin
        tally_nxt = tally_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      tally_r <= '0;
    end else begin
      slot_r  <= slot_nxt;
      tally_r <= tally_nxt;
    end
  end

  tsoa_div_lane u_off_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (off_acc_r),
    .divisor  (tally_r),
    .quotient (off_mean)
  );

  tsoa_div_lane u_rtt_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (rtt_acc_r),
    .divisor  (tally_r),
    .quotient (rtt_mean)
  );

  assign stat.tally = tally_r;
  assign out_tdata  = {{tsoa_pkg::OUT_PAD_W{1'b0}}, samples_r, rtt_mean_r, off_mean_r};

  a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (tally_r <= tsoa_pkg::TALLY_MAX) && (slot_r <= tsoa_pkg::SLOT_LAST))
    else $error("ring slot or sample count out of range");

  a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> (tally_r != '0) && (tally_r >= $past(tally_r)))
    else $error("sample count did not advance or saturate on a ring write");

  a_slot_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write && (slot_r == tsoa_pkg::SLOT_LAST) |=> (slot_r == '0))
    else $error("ring write slot did not wrap after the last entry");

endmodule

### hdl/tsoa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-sync offset averager: controller
// Sequences difference, ring write, window sweep and division for one beat,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module tsoa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  tsoa_pkg::tsoa_stat_t stat,
  output tsoa_pkg::tsoa_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_CALC,
    S_WRITE,
    S_SUM,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [tsoa_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [tsoa_pkg::DIV_CNT_W-1:0]  bit_r, bit_nxt;
  logic                            out_tvalid_r, out_tvalid_nxt;
  logic                            sum_last;

  assign sum_last = (tsoa_pkg::TALLY_W'(idx_r) + tsoa_pkg::TALLY_W'(1)) == stat.tally;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    cmd.rd_idx = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.write     = 1'b1;
        cmd.acc_clear = 1'b1;
        idx_nxt       = '0;
        state_nxt     = S_SUM;
      end
      S_SUM: begin
        cmd.acc_add = 1'b1;
        if (sum_last) begin
          state_nxt = S_LOAD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        bit_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_r == tsoa_pkg::DIV_LAST) begin
          state_nxt = S_DONE;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.res_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      bit_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      bit_r        <= bit_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  a_sweep_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> (tsoa_pkg::TALLY_W'(idx_r) < stat.tally))
    else $error("window sweep reads beyond the written samples");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (bit_r == tsoa_pkg::DIV_LAST) |=> (state_r == S_DONE))
    else $error("division did not finish after the last quotient bit");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten before its beat was taken");

endmodule

### hdl/time_sync_offset_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-sync offset averager
// Takes one four-timestamp sync exchange per input beat, forms the clock
// offset and round-trip delay, keeps them in a window of WINDOW_DEPTH
// exchanges and returns both window means with the sample count.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Width  Contents
// in_      in   256    request_sent, server_receive, server_send, reply_arrival
// out_     out  136    mean_offset, mean_round_trip, samples_in_window, pad
//
// One beat is processed at a time: after the accepting edge, the controller
// forms the differences, the offset and round trip and the ring update, reads
// every stored sample once to sum the window, loads the divider, runs
// bit-serial division of ACC_W (67 at a depth of 5) quotient bits in two
// parallel lanes and then registers the result.
// The next beat is taken in the cycle after the result is registered, while
// it still waits on out_tready. Reset clears the write slot, sample count and
// valid flag; ring contents are only read once written. Stalls on the output
// hold the result and the controller only in its final state.
// ----------------------------------------------------------------------------
module time_sync_offset_averager (
  input  logic                             clk,
  input  logic                             rst_n,
  // request_sent_time [63:0], server_receive_time [127:64],
  // server_send_time [191:128], reply_arrival_time [255:192]
  input  logic [tsoa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // mean_offset [63:0], mean_round_trip [127:64], samples_in_window [130:128],
  // zero pad [135:131]
  output logic [tsoa_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready
);

  // Commands down from the controller, sample count back up.
  tsoa_pkg::tsoa_cmd_t  cmd;
  tsoa_pkg::tsoa_stat_t stat;

  tsoa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Differences, rings, window sums and the divider lanes.
  tsoa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

### dv/tb_time_sync_offset_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-sync offset averager: self-checking testbench
// Feeds four-timestamp sync exchanges into the block and predicts the offset
// and round-trip window means for every input beat. Each result beat is
// checked field by field against the oldest prediction. The run has a
// directed part at the arithmetic edges, then three random phases with
// different idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_time_sync_offset_averager;

  localparam int          RANDOM_PER_PHASE = 580;
  localparam int          STALL_LIMIT      = 2000;  // cycles with no beat at all
  localparam int          SETTLE_CYCLES    = 100;   // one item's latency plus margin
  localparam logic [63:0] TS_ZERO          = 64'h0000_0000_0000_0000;
  localparam logic [63:0] TS_ONES          = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TS_MSB           = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TS_MAX_POS       = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [63:0] sent;
    logic [63:0] srv_rx;
    logic [63:0] srv_tx;
    logic [63:0] arrive;
  } exchange_t;

  typedef struct {
    logic signed [63:0]              mean_offset;
    logic signed [63:0]              mean_round_trip;
    logic [tsoa_pkg::SAMPLES_W-1:0]  samples;
    logic [tsoa_pkg::OUT_PAD_W-1:0]  pad;
  } window_mean_t;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic [tsoa_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [tsoa_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;

  time_sync_offset_averager u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #10 clk = ~clk;

  // Pending exchanges and the window means still owed by the block.
  exchange_t    exchange_q[$];
  window_mean_t expected_means_q[$];
  exchange_t    in_flight;

  // Predictor copy of the sample window.
  logic [63:0] offset_hist[tsoa_pkg::WINDOW_DEPTH];
  logic [63:0] round_trip_hist[tsoa_pkg::WINDOW_DEPTH];
  int          next_slot   = 0;
  int          window_fill = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_sent    = 0;
  int means_checked = 0;
  int error_count   = 0;
  int stall_cycles  = 0;
  int items_queued  = 0;

  // Store one exchange in the window and work out both window means.
  function automatic window_mean_t predict_window_means(input exchange_t ex);
    logic [63:0]         off_diff;
    logic [63:0]         rtt;
    logic signed [127:0] off_sum;
    logic signed [127:0] rtt_sum;
    logic signed [127:0] off_q;
    logic signed [127:0] rtt_q;
    window_mean_t        r;
    int                  i;
    // Differences wrap modulo 2^64; halve with truncation toward zero.
    off_diff = (ex.srv_rx - ex.sent) - (ex.srv_tx - ex.arrive);
    rtt      = (ex.arrive - ex.sent) - (ex.srv_rx - ex.srv_tx);
    offset_hist[next_slot]     = $signed(off_diff) / 64'sd2;
    round_trip_hist[next_slot] = rtt;
    next_slot = (next_slot == tsoa_pkg::WINDOW_DEPTH - 1) ? 0 : next_slot + 1;
    if (window_fill < tsoa_pkg::WINDOW_DEPTH) window_fill++;
    // Sum exactly in 128 bits, then divide with signed truncation.
    off_sum = '0;
    rtt_sum = '0;
    for (i = 0; i < window_fill; i++) begin
      off_sum = off_sum + $signed(offset_hist[i]);
      rtt_sum = rtt_sum + $signed(round_trip_hist[i]);
    end
    off_q = off_sum / 128'(window_fill);
    rtt_q = rtt_sum / 128'(window_fill);
    r.mean_offset     = off_q[63:0];
    r.mean_round_trip = rtt_q[63:0];
    r.samples         = tsoa_pkg::SAMPLES_W'(window_fill);
    r.pad             = '0;
    return r;
  endfunction

  function automatic exchange_t mk_exchange(input logic [63:0] t1, t2, t3, t4);
    exchange_t ex;
    ex.sent   = t1;
    ex.srv_rx = t2;
    ex.srv_tx = t3;
    ex.arrive = t4;
    return ex;
  endfunction

  function automatic logic [63:0] rand_ts();
    return {$urandom, $urandom};
  endfunction

  // Mostly plausible exchanges; some broken ordering, some raw noise and
  // some values clustered round the wrap points.
  function automatic exchange_t random_exchange();
    exchange_t   ex;
    logic [63:0] skew;
    logic [63:0] fwd;
    logic [63:0] back;
    logic [63:0] hold;
    int unsigned pick;
    pick = $urandom_range(99);
    skew = $signed(rand_ts()) >>> $urandom_range(63, 16);
    fwd  = 64'($urandom_range(1_000_000));
    back = 64'($urandom_range(1_000_000));
    hold = 64'($urandom_range(5000));
    ex.sent   = rand_ts();
    ex.srv_rx = ex.sent + skew + fwd;
    ex.srv_tx = ex.srv_rx + hold;
    ex.arrive = ex.sent + fwd + hold + back;
    if (pick >= 95) begin
      // Corner clusters: next to zero, all ones and the sign boundary.
      ex.sent   = (pick[0] ? TS_MSB : TS_ZERO) + 64'($urandom_range(3)) - 64'd2;
      ex.srv_rx = (pick[1] ? TS_MAX_POS : TS_ONES) + 64'($urandom_range(3)) - 64'd1;
      ex.srv_tx = ($urandom_range(1) ? TS_MSB : TS_ZERO) - 64'($urandom_range(3));
      ex.arrive = ($urandom_range(1) ? TS_ONES : TS_MAX_POS) - 64'($urandom_range(3));
    end else if (pick >= 80) begin
      ex = mk_exchange(rand_ts(), rand_ts(), rand_ts(), rand_ts());
    end else if (pick >= 70) begin
      // Reply before request, or server times swapped.
      if (pick[0]) begin
        ex.arrive = ex.sent - back;
      end else begin
        ex.srv_tx = ex.srv_rx - hold - 64'd1;
      end
    end
    return ex;
  endfunction

  // Sender: hold the beat until accepted, predict on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_means_q.push_back(predict_window_means(in_flight));
        beats_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (exchange_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = exchange_q.pop_front();
          in_tdata  <= {in_flight.arrive, in_flight.srv_tx,
                        in_flight.srv_rx, in_flight.sent};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: throttle out_tready and check every result beat.
  always @(posedge clk) begin
    window_mean_t got;
    window_mean_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.mean_offset     = out_tdata[tsoa_pkg::TS_W-1:0];
        got.mean_round_trip = out_tdata[2*tsoa_pkg::TS_W-1:tsoa_pkg::TS_W];
        got.samples         = out_tdata[tsoa_pkg::OUT_FIELD_W-1:2*tsoa_pkg::TS_W];
        got.pad             = out_tdata[tsoa_pkg::OUT_TDATA_W-1:tsoa_pkg::OUT_FIELD_W];
        if (expected_means_q.size() == 0) begin
          $display("%0t unexpected result beat: got offset %0d round trip %0d samples %0d",
                   $time, got.mean_offset, got.mean_round_trip, got.samples);
          error_count++;
        end else begin
          want = expected_means_q.pop_front();
          means_checked++;
          if (got.mean_offset !== want.mean_offset) begin
            $display("%0t mean_offset mismatch: expected %0d, got %0d",
                     $time, want.mean_offset, got.mean_offset);
            error_count++;
          end
          if (got.mean_round_trip !== want.mean_round_trip) begin
            $display("%0t mean_round_trip mismatch: expected %0d, got %0d",
                     $time, want.mean_round_trip, got.mean_round_trip);
            error_count++;
          end
          if (got.samples !== want.samples) begin
            $display("%0t samples_in_window mismatch: expected %0d, got %0d",
                     $time, want.samples, got.samples);
            error_count++;
          end
          if (got.pad !== want.pad) begin
            $display("%0t tdata pad mismatch: expected %0h, got %0h",
                     $time, want.pad, got.pad);
            error_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: give up after a long stretch with no beat on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t timeout: no beat for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_means_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus and run control.
  initial begin
    int phase;
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero and all-ones stamps, wrapped differences, halving of odd
    // and extreme offsets, and a full window whose sums leave 64 bits.
    send_idle_pct = 20;
    recv_idle_pct = 72;
    exchange_q.push_back(mk_exchange(TS_ZERO, TS_ZERO, TS_ZERO, TS_ZERO));
    exchange_q.push_back(mk_exchange(TS_ONES, TS_ONES, TS_ONES, TS_ONES));
    exchange_q.push_back(mk_exchange(TS_ZERO, TS_ZERO, 64'd1, TS_ZERO));
    exchange_q.push_back(mk_exchange(TS_ZERO, TS_ZERO, 64'd3, TS_ZERO));
    exchange_q.push_back(mk_exchange(TS_ZERO, 64'd3, TS_ZERO, TS_ZERO));
    exchange_q.push_back(mk_exchange(TS_ZERO, TS_MSB, TS_ZERO, TS_ZERO));
    exchange_q.push_back(mk_exchange(TS_ZERO, TS_MAX_POS, TS_ZERO, TS_ZERO));
    exchange_q.push_back(mk_exchange(TS_ONES, TS_ZERO, TS_ONES, TS_ZERO));
    exchange_q.push_back(mk_exchange(TS_ZERO, TS_ZERO, TS_ZERO, TS_MSB));
    exchange_q.push_back(mk_exchange(TS_ONES, TS_ZERO, TS_ZERO, TS_MAX_POS));
    repeat (6) exchange_q.push_back(mk_exchange(TS_ZERO, TS_MAX_POS, TS_ZERO, TS_ZERO));
    repeat (6) exchange_q.push_back(mk_exchange(TS_MAX_POS, TS_ZERO, TS_MSB, TS_ONES));
    exchange_q.push_back(mk_exchange(64'd1000, 64'd5003, 64'd5010, 64'd1017));
    items_queued = exchange_q.size();

    // Three random phases; the sender pauses between them until every
    // expected result has come back.
    for (phase = 0; phase <= 3; phase++) begin
      if (phase > 0) begin
        case (phase)
          1: begin
            send_idle_pct = 20;
            recv_idle_pct = 72;
          end
          2: begin
            send_idle_pct = 72;
            recv_idle_pct = 20;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        for (n = 0; n < RANDOM_PER_PHASE; n++) exchange_q.push_back(random_exchange());
        items_queued += RANDOM_PER_PHASE;
      end
      do @(posedge clk);
      while (means_checked < items_queued);
    end

    // Let any stray result surface before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d sync exchanges and checked %0d window means (depth %0d),",
             beats_sent, means_checked, tsoa_pkg::WINDOW_DEPTH);
    $display("with both sides stalling in turn and then running flat out.");
    if (error_count == 0 && expected_means_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/tsoa_pkg.sv
hdl/tsoa_div_lane.sv
hdl/tsoa_datapath.sv
hdl/tsoa_ctrl.sv
hdl/time_sync_offset_averager.sv
dv/tb_time_sync_offset_averager.sv
